>>> hw/rtl/cmrf_pkg.sv
// Shared types and constants for the causal median run feature block.
// No dependencies; used by every module in hw/rtl.
package cmrf_pkg;

  localparam int DUR_W      = 20;  // duration and window entries
  localparam int ARG_W      = 21;  // log argument (twice a duration)
  localparam int LOG_W      = 21;  // log2 in Q.16, integer part up to 20
  localparam int LM_W       = 17;  // log_to_median
  localparam int SGN_W      = 14;  // mark_sign
  localparam int RAT_W      = 15;  // ratio_prev and ratio_next
  localparam int LIM_W      = 14;  // ratio_limit register
  localparam int WINDOW_DEF = 31;

  localparam logic [DUR_W-1:0] DUR_FLOOR    = 20'd16;
  localparam logic [DUR_W-1:0] FALLBACK_RST = 20'd1600;
  localparam logic [LIM_W-1:0] LIMIT_RST    = 14'd12288;
  localparam logic [23:0]      LN2_Q24      = 24'd11629080;
  localparam logic [SGN_W-1:0] SIGN_POS     = 14'h1000;
  localparam logic [SGN_W-1:0] SIGN_NEG     = 14'h3000;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic {
    CFG_FALLBACK = 1'b0,
    CFG_LIMIT    = 1'b1
  } cfg_idx_e;

  // Controls broadcast from the sequencer to every window cell.
  typedef struct packed {
    logic shift;  // take the neighbor's stored value
    logic load;   // copy own value into the circulating slot, clear rank
    logic step;   // pass the circulating slot on and update rank
  } cell_ctrl_t;

endpackage

>>> hw/rtl/cmrf_log2.sv
// Sequential log2 unit: Q.16 result, one mantissa squaring per cycle.
// Depends on cmrf_pkg.
module cmrf_log2 import cmrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ARG_W-1:0] arg_i,
  output logic             busy_o,
  output logic [LOG_W-1:0] log_o
);

  logic        busy_q, busy_d;
  logic [3:0]  it_q, it_d;
  logic [31:0] y_q, y_d;
  logic [4:0]  n_q, n_d;
  logic [15:0] frac_q, frac_d;
  logic [4:0]  n_new;
  logic [63:0] sq;
  logic [32:0] t;

  always_comb begin
    n_new = 5'd0;
    for (int b = 0; b < ARG_W; b++) begin
      if (arg_i[b]) begin
        n_new = 5'(b);
      end
    end
  end

  assign sq = 64'(y_q) * 64'(y_q);
  assign t  = sq[63:31];

  always_comb begin
    busy_d = busy_q;
    it_d   = it_q;
    y_d    = y_q;
    n_d    = n_q;
    frac_d = frac_q;
    if (start_i) begin
      busy_d = 1'b1;
      it_d   = 4'd0;
      n_d    = n_new;
      y_d    = 32'(arg_i) << (5'd31 - n_new);
      frac_d = 16'd0;
    end else if (busy_q) begin
      if (t[32]) begin
        y_d    = t[32:1];
        frac_d = {frac_q[14:0], 1'b1};
      end else begin
        y_d    = t[31:0];
        frac_d = {frac_q[14:0], 1'b0};
      end
      it_d = it_q + 4'd1;
      if (it_q == 4'd15) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= 4'd0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    n_q    <= n_d;
    frac_q <= frac_d;
  end

  assign busy_o = busy_q;
  assign log_o  = {n_q, frac_q};

endmodule

>>> hw/rtl/cmrf_cell.sv
// One window cell: a stored mark duration, a circulating slot and a rank counter.
// Depends on cmrf_pkg.
module cmrf_cell import cmrf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int IDX    = 0,
  localparam int CW = $clog2(WINDOW + 1),
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CW-1:0]    cnt_i,
  input  logic [CW-1:0]    k_hi_i,
  input  logic [CW-1:0]    k_lo_i,
  input  logic [DUR_W-1:0] val_i,
  output logic [DUR_W-1:0] val_o,
  input  logic [DUR_W-1:0] circ_val_i,
  input  logic [IW-1:0]    circ_idx_i,
  output logic [DUR_W-1:0] circ_val_o,
  output logic [IW-1:0]    circ_idx_o,
  output logic [DUR_W-1:0] hi_o,
  output logic [DUR_W-1:0] lo_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DUR_W-1:0] val_q, circ_val_q;
  logic [IW-1:0]    circ_idx_q, rank_q;
  logic             circ_vld, mine_vld, below;

  assign circ_vld = CW'(circ_idx_q) < cnt_i;
  assign mine_vld = CW'(MY_IDX) < cnt_i;
  // Equal values are ordered by cell position so that ranks are unique.
  assign below = circ_vld &&
                 ((circ_val_q < val_q) || ((circ_val_q == val_q) && (circ_idx_q < MY_IDX)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      val_q <= val_i;
    end
    if (ctrl_i.load) begin
      circ_val_q <= val_q;
      circ_idx_q <= MY_IDX;
      rank_q     <= '0;
    end else if (ctrl_i.step) begin
      circ_val_q <= circ_val_i;
      circ_idx_q <= circ_idx_i;
      if (below) begin
        rank_q <= rank_q + IW'(1);
      end
    end
  end

  assign val_o      = val_q;
  assign circ_val_o = circ_val_q;
  assign circ_idx_o = circ_idx_q;
  assign hi_o = (mine_vld && (CW'(rank_q) == k_hi_i)) ? val_q : '0;
  assign lo_o = (mine_vld && (CW'(rank_q) == k_lo_i)) ? val_q : '0;

endmodule

>>> hw/rtl/causal_median_run_features.sv
// Causal running-median run feature extractor, top level.
// A push word yields its result (for the previous run) after the rank circulation
// around the cell ring and then the 16-step log2 unit on the median; a flush yields
// its result from its own state. One word is in flight at a time, so no new word is
// taken until the last one is through.
// Reset (async, active low) clears count, held run and the registers to defaults.
module causal_median_run_features import cmrf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [0] key_mark, [20:1] duration, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [16:0] log_to_median, [30:17] mark_sign,
                                      // [45:31] ratio_prev, [60:46] ratio_next
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_RANK, ST_PICK, ST_WAITL, ST_LOGM,
    ST_MULA, ST_MULB, ST_MULC, ST_FIN, ST_FLUSH
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [DUR_W-1:0] fallback_q;
  logic [LIM_W-1:0] limit_q;

  // Run in progress and held run.
  logic [CW-1:0]    cnt_q, rcnt_q;
  logic             mark_q;
  logic [ARG_W-1:0] med2_q;
  logic [LOG_W-1:0] ld_q, lmed_q;
  logic [45:0]      prod_q;
  logic             sgn_a_q, sgn_b_q;
  logic [LM_W-1:0]  lm_q;
  logic [LIM_W-1:0] rmag_q;
  logic             held_valid_q, held_mark_q;
  logic [LM_W-1:0]  held_lm_q;
  logic [RAT_W-1:0] held_rp_q;
  logic [LOG_W-1:0] held_l_q;
  logic             out_valid_q;
  logic [63:0]      out_data_q;

  logic             in_acc, out_free, op_flush, run_mark, emit;
  logic [DUR_W-1:0] dur_in, dur_fl, fb_fl;
  cell_ctrl_t       ctrl;
  logic [CW-1:0]    k_hi, k_lo;
  logic             log_start, log_busy;
  logic [ARG_W-1:0] log_arg;
  logic [LOG_W-1:0] log_res;

  logic [DUR_W-1:0] cval [WINDOW];
  logic [DUR_W-1:0] ccirc [WINDOW];
  logic [IW-1:0]    cidx [WINDOW];
  logic [DUR_W-1:0] chi [WINDOW];
  logic [DUR_W-1:0] clo [WINDOW];
  logic [DUR_W-1:0] hi_sel, lo_sel;

  logic signed [22:0] diff_a, diff_b, diff_sel;
  logic [21:0]        mag_sel;
  logic [46:0]        rnd_sum;
  logic [18:0]        rnd;
  logic [LM_W-1:0]    lm_sat;
  logic [LIM_W-1:0]   rmag_cl;
  logic [RAT_W-1:0]   rn_val, rp_val;
  logic [SGN_W-1:0]   held_sign;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op_flush      = (s_axis_tuser[0] == OP_FLUSH);
  assign run_mark      = s_axis_tdata[0];
  assign dur_in        = s_axis_tdata[20:1];
  assign dur_fl        = (dur_in < DUR_FLOOR) ? DUR_FLOOR : dur_in;
  assign fb_fl         = (fallback_q < DUR_FLOOR) ? DUR_FLOOR : fallback_q;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // A result word leaves when a finished push or a flush finds a held run.
  assign emit = ((state_q == ST_FIN) || (state_q == ST_FLUSH)) && out_free && held_valid_q;

  // Cell controls: a mark enters at cell 0 and the oldest falls off the far end.
  assign ctrl.shift = in_acc && !op_flush && run_mark;
  assign ctrl.load  = (state_q == ST_LOAD);
  assign ctrl.step  = (state_q == ST_RANK);

  // Ranks that hold the middle value(s) of the sorted window.
  assign k_hi = cnt_q >> 1;
  assign k_lo = k_hi - CW'(1);

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
    cmrf_cell #(.WINDOW(WINDOW), .IDX(i)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cnt_i      (cnt_q),
      .k_hi_i     (k_hi),
      .k_lo_i     (k_lo),
      .val_i      ((i == 0) ? dur_fl : cval[PREV]),
      .val_o      (cval[i]),
      .circ_val_i (ccirc[PREV]),
      .circ_idx_i (cidx[PREV]),
      .circ_val_o (ccirc[i]),
      .circ_idx_o (cidx[i]),
      .hi_o       (chi[i]),
      .lo_o       (clo[i])
    );
  end

  // Exactly one valid cell matches each rank, the others give zero.
  always_comb begin
    hi_sel = '0;
    lo_sel = '0;
    for (int i = 0; i < WINDOW; i++) begin
      hi_sel = hi_sel | chi[i];
      lo_sel = lo_sel | clo[i];
    end
  end

  // The log unit first works on the new duration while the ring ranks,
  // then on twice the median.
  assign log_start = (in_acc && !op_flush) || ((state_q == ST_WAITL) && !log_busy);
  assign log_arg   = (state_q == ST_WAITL) ? med2_q : ARG_W'(dur_fl);

  cmrf_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .arg_i   (log_arg),
    .busy_o  (log_busy),
    .log_o   (log_res)
  );

  // log2(2d) is log2(d) plus one, so the median feature needs no extra log.
  assign diff_a   = $signed({2'b00, ld_q}) + 23'sd65536 - $signed({2'b00, lmed_q});
  assign diff_b   = $signed({2'b00, held_l_q}) - $signed({2'b00, ld_q});
  assign diff_sel = (state_q == ST_MULA) ? diff_a : diff_b;
  assign mag_sel  = diff_sel[22] ? 22'(-diff_sel) : 22'(diff_sel);

  // Round the Q.40 product to Q.12, ties away from zero on the magnitude.
  assign rnd_sum = 47'(prod_q) + (47'd1 << 27);
  assign rnd     = rnd_sum[46:28];

  always_comb begin
    if (!sgn_a_q) begin
      lm_sat = (rnd > 19'd65535) ? 17'h0FFFF : rnd[16:0];
    end else begin
      lm_sat = (rnd > 19'd65536) ? 17'h10000 : 17'(-rnd);
    end
  end

  assign rmag_cl   = (rnd > 19'(limit_q)) ? limit_q : rnd[13:0];
  // The next ratio of the held run and the previous ratio of the new run are negatives.
  assign rn_val    = sgn_b_q ? RAT_W'(-{1'b0, rmag_q}) : RAT_W'({1'b0, rmag_q});
  assign rp_val    = held_valid_q ? (sgn_b_q ? RAT_W'({1'b0, rmag_q})
                                             : RAT_W'(-{1'b0, rmag_q})) : '0;
  assign held_sign = held_mark_q ? SIGN_POS : SIGN_NEG;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fallback_q   <= FALLBACK_RST;
      limit_q      <= LIMIT_RST;
      cnt_q        <= '0;
      rcnt_q       <= '0;
      held_valid_q <= 1'b0;
      held_mark_q  <= 1'b0;
      held_lm_q    <= '0;
      held_rp_q    <= '0;
      held_l_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FALLBACK: fallback_q <= cfg_data_i;
          CFG_LIMIT:    limit_q    <= cfg_data_i[LIM_W-1:0];
          default:      fallback_q <= fallback_q;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_flush) begin
              state_q <= ST_FLUSH;
            end else begin
              if (run_mark && (cnt_q != CW'(WINDOW))) begin
                cnt_q <= cnt_q + CW'(1);
              end
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          rcnt_q  <= '0;
          state_q <= ST_RANK;
        end
        ST_RANK: begin
          rcnt_q <= rcnt_q + CW'(1);
          if (rcnt_q == CW'(WINDOW - 1)) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          state_q <= ST_WAITL;
        end
        ST_WAITL: begin
          if (!log_busy) begin
            state_q <= ST_LOGM;
          end
        end
        ST_LOGM: begin
          if (!log_busy) begin
            state_q <= ST_MULA;
          end
        end
        ST_MULA: state_q <= ST_MULB;
        ST_MULB: state_q <= ST_MULC;
        ST_MULC: state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            held_valid_q <= 1'b1;
            held_mark_q  <= mark_q;
            held_lm_q    <= lm_q;
            held_rp_q    <= rp_val;
            held_l_q     <= ld_q;
            state_q      <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            cnt_q        <= '0;
            held_valid_q <= 1'b0;
            held_mark_q  <= 1'b0;
            held_lm_q    <= '0;
            held_rp_q    <= '0;
            held_l_q     <= '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && !op_flush) begin
      mark_q <= run_mark;
    end
    if (state_q == ST_PICK) begin
      if (cnt_q == '0) begin
        med2_q <= {fb_fl, 1'b0};
      end else if (cnt_q[0]) begin
        med2_q <= {hi_sel, 1'b0};
      end else begin
        med2_q <= ARG_W'({1'b0, hi_sel} + {1'b0, lo_sel});
      end
    end
    if ((state_q == ST_WAITL) && !log_busy) begin
      ld_q <= log_res;
    end
    if ((state_q == ST_LOGM) && !log_busy) begin
      lmed_q <= log_res;
    end
    if (state_q == ST_MULA) begin
      prod_q  <= 46'(mag_sel) * 46'(LN2_Q24);
      sgn_a_q <= diff_sel[22];
    end
    if (state_q == ST_MULB) begin
      lm_q    <= lm_sat;
      prod_q  <= 46'(mag_sel) * 46'(LN2_Q24);
      sgn_b_q <= diff_sel[22];
    end
    if (state_q == ST_MULC) begin
      rmag_q <= rmag_cl;
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_data_q <= {3'b000, rn_val, held_rp_q, held_sign, held_lm_q};
    end
    if ((state_q == ST_FLUSH) && out_free) begin
      out_data_q <= {3'b000, RAT_W'(0), held_rp_q, held_sign, held_lm_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> tb/testbench.sv
// Testbench for causal_median_run_features: random and directed run words,
// checked against an in-bench predictor of the median and log features.
// Depends on cmrf_pkg and the block's top level in hw/rtl.
`timescale 1ns / 100ps

module testbench;
  import cmrf_pkg::*;

  typedef struct {
    op_e         op;
    logic        mark;
    logic [19:0] dur;
  } run_word_t;

  typedef struct {
    logic [16:0] log_med;
    logic [13:0] sign;
    logic [14:0] r_prev;
    logic [14:0] r_next;
  } feat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [19:0] cfg_data_i = '0;

  causal_median_run_features dut (.*);

  // The clock runs with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: the mark window, the held run and the two registers.
  logic [19:0] win_q [31];
  int unsigned mark_cnt, wr_slot;
  bit          hold_v;
  int          hold_lm, hold_rp;
  bit          hold_mark;
  int unsigned hold_dur;
  int unsigned fb_reg, lim_reg;

  run_word_t pending_q[$];
  feat_t     feat_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        hold_off = 1'b0;
  bit        in_taken = 1'b0;
  int        in_gap = 0, out_gap = 0;

  function automatic int unsigned log2_q16(int unsigned x);
    int unsigned n, t, frac;
    longint unsigned y;
    n = 0; t = x; frac = 0;
    while (t > 1) begin
      t >>= 1;
      n++;
    end
    y = longint'(x) << (31 - n);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      frac <<= 1;
      if (y >= 64'h1_0000_0000) begin
        frac |= 1;
        y >>= 1;
      end
    end
    return (n << 16) | frac;
  endfunction

  function automatic int ln_q12(int unsigned a, int unsigned b);
    longint d;
    longint unsigned m;
    d = longint'(log2_q16(a)) - longint'(log2_q16(b));
    m = d < 0 ? -d : d;
    m = (m * 64'd11629080 + (64'd1 << 27)) >> 28;
    return d < 0 ? -int'(m) : int'(m);
  endfunction

  function automatic int clamp_lim(int v);
    if (v > int'(lim_reg)) return int'(lim_reg);
    if (v < -int'(lim_reg)) return -int'(lim_reg);
    return v;
  endfunction

  function automatic int unsigned twice_median();
    int unsigned s[31];
    int unsigned v, j;
    if (mark_cnt == 0) return 2 * (fb_reg < 16 ? 16 : fb_reg);
    for (int i = 0; i < mark_cnt; i++) begin
      v = win_q[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    if (mark_cnt & 1) return 2 * s[mark_cnt/2];
    return s[mark_cnt/2 - 1] + s[mark_cnt/2];
  endfunction

  function automatic void clear_runs();
    mark_cnt = 0; wr_slot = 0; hold_v = 0; hold_lm = 0;
    hold_mark = 0; hold_rp = 0; hold_dur = 0;
  endfunction

  // Advances the predictor by one accepted word and queues any features it releases.
  function automatic void predict_run(run_word_t w);
    feat_t f;
    int unsigned d, dp;
    int lm;
    if (hold_v) begin
      f.log_med = hold_lm[16:0];
      f.sign    = hold_mark ? SIGN_POS : SIGN_NEG;
      f.r_prev  = hold_rp[14:0];
    end
    if (w.op == OP_FLUSH) begin
      if (hold_v) begin
        f.r_next = '0;
        feat_q.push_back(f);
      end
      clear_runs();
      return;
    end
    d = w.dur < 16 ? 16 : w.dur;
    if (hold_v) begin
      lm = clamp_lim(ln_q12(hold_dur, d));
      f.r_next = lm[14:0];
      feat_q.push_back(f);
    end
    dp = hold_v ? hold_dur : d;
    if (w.mark) begin
      win_q[wr_slot] = 20'(d);
      wr_slot = (wr_slot + 1 >= 31) ? 0 : wr_slot + 1;
      if (mark_cnt < 31) mark_cnt++;
    end
    lm = ln_q12(2 * d, twice_median());
    if (lm > 65535) lm = 65535;
    if (lm < -65536) lm = -65536;
    hold_lm = lm; hold_mark = w.mark; hold_rp = clamp_lim(ln_q12(d, dp));
    hold_dur = d; hold_v = 1;
  endfunction

  // Input sampler: an input word counts as taken at the rising edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_run(pending_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // Driver: offers queued words after a random gap, changes at the falling edge.
  always @(negedge clk_i) begin
    bit taken;
    if (rst_ni) begin
      taken = in_taken;
      in_taken = 1'b0;
      if (taken) begin
        in_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (s_axis_tvalid && !taken) begin
        // Keep offering the same word.
      end else if (pending_q.size() > 0 && in_gap == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_q[0].op;
        s_axis_tdata  <= {3'b000, pending_q[0].dur, pending_q[0].mark};
      end else begin
        s_axis_tvalid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
      if (hold_off) m_axis_tready <= 1'b0;
      else if (out_gap > 0) begin
        m_axis_tready <= 1'b0;
        out_gap--;
      end else m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compares each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    feat_t e;
    cycles++;
    if (cycles > 3_000_000) begin
      $display("testbench: FAIL");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_gap = $urandom_range(0, 6);
      if (feat_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = feat_q.pop_front();
        if (m_axis_tdata !== {3'b000, e.r_next, e.r_prev, e.sign, e.log_med}) begin
          $display("%0t mismatch expected lm=%h sg=%h rp=%h rn=%h actual %h", $time,
                   e.log_med, e.sign, e.r_prev, e.r_next, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [19:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_FALLBACK) fb_reg = val;
    else lim_reg = val[13:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits for the block to drain; a trailing push may still be at work.
  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || feat_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [19:0] rand_dur();
    case ($urandom_range(0, 9))
      0: return 20'($urandom_range(0, 20));
      1: return 20'($urandom);
      2: return 20'hFFFFF - 20'($urandom_range(0, 3));
      default: return 20'($urandom_range(400, 4000));
    endcase
  endfunction

  task automatic add_word(op_e op, logic mark, logic [19:0] dur);
    run_word_t w;
    w.op = op; w.mark = mark; w.dur = dur;
    pending_q.push_back(w);
  endtask

  initial begin
    fb_reg = 1600; lim_reg = 12288;
    clear_runs();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: flush with nothing held, space before any mark, extremes of duration.
    add_word(OP_FLUSH, 1'b1, 20'hFFFFF);
    add_word(OP_PUSH, 1'b0, 20'd0);
    add_word(OP_PUSH, 1'b1, 20'hFFFFF);
    add_word(OP_PUSH, 1'b0, 20'd1);
    add_word(OP_PUSH, 1'b1, 20'd16);
    add_word(OP_PUSH, 1'b1, 20'd800);
    add_word(OP_PUSH, 1'b0, 20'hAAAAA);
    add_word(OP_PUSH, 1'b1, 20'h55555);
    add_word(OP_FLUSH, 1'b0, 20'd0);
    drain();

    // Low fallback is raised to the duration floor; zero limit silences the ratios.
    write_reg(CFG_FALLBACK, 20'd3);
    write_reg(CFG_LIMIT, 20'd0);
    add_word(OP_PUSH, 1'b0, 20'd50);
    add_word(OP_PUSH, 1'b0, 20'hFFFFF);
    add_word(OP_PUSH, 1'b1, 20'd17);
    add_word(OP_FLUSH, 1'b0, 20'd0);
    drain();
    write_reg(CFG_FALLBACK, 20'hFFFFF);
    write_reg(CFG_LIMIT, 20'h03FFF);
    add_word(OP_PUSH, 1'b0, 20'd16);
    add_word(OP_PUSH, 1'b1, 20'd16);
    add_word(OP_FLUSH, 1'b0, 20'd0);
    drain();

    // Random phases: mostly long keyed sequences that wrap the window.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_FALLBACK, 20'd1600); write_reg(CFG_LIMIT, 20'd12288); end
        1: begin write_reg(CFG_FALLBACK, 20'd16); write_reg(CFG_LIMIT, 20'd1); end
        2: begin
          write_reg(CFG_FALLBACK, 20'($urandom));
          write_reg(CFG_LIMIT, 20'($urandom));
        end
        3: begin write_reg(CFG_FALLBACK, 20'd0); write_reg(CFG_LIMIT, 20'd16383); end
        default: begin write_reg(CFG_FALLBACK, 20'd2400); write_reg(CFG_LIMIT, 20'd8000); end
      endcase
      for (int i = 0; i < 400; i++) begin
        if ($urandom_range(0, 60) == 0) add_word(OP_FLUSH, 1'($urandom), 20'($urandom));
        else add_word(OP_PUSH, 1'($urandom), rand_dur());
      end
      add_word(OP_FLUSH, 1'b0, 20'd0);
      if (ph == 1) begin
        // Hold the result side off long enough that the input side stalls.
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    if (errors == 0 && feat_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
